// File: src/size_class_slab_allocator_top_defines.svh
// Assertion macros for the slab allocator.
`ifndef SIZE_CLASS_SLAB_ALLOCATOR_TOP_DEFINES_SVH
`define SIZE_CLASS_SLAB_ALLOCATOR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// checked outside reset
`define SCSA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define SCSA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCSA_ASSERT(label, clk, rst_n, prop, msg)
`define SCSA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: src/scsa_pkg.sv
`default_nettype none

package scsa_pkg;

    localparam int MAX_PAGES_DEF = 32;
    localparam int PCNT_W        = 7;
    localparam int MAP_W         = 58;
    localparam int ADDR_W        = 32;
    localparam int SIZE_W        = 16;
    localparam int MAX_BYTES     = 512;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_ZERO     = 3'd1,
        STAT_LARGE    = 3'd2,
        STAT_OOM      = 3'd3,
        STAT_RANGE    = 3'd4,
        STAT_MISALIGN = 3'd5,
        STAT_NOTALLOC = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        CLS_32  = 2'd0,
        CLS_64  = 2'd1,
        CLS_128 = 2'd2,
        CLS_512 = 2'd3
    } cls_t;

    // smallest class that holds sz (sz already known to be 1..512)
    function automatic cls_t size_class(input logic [SIZE_W-1:0] sz);
        cls_t c;
        if (sz <= SIZE_W'(32))
            c = CLS_32;
        else if (sz <= SIZE_W'(64))
            c = CLS_64;
        else if (sz <= SIZE_W'(128))
            c = CLS_128;
        else
            c = CLS_512;
        return c;
    endfunction

    // busy bits of one class, unused positions padded as busy
    function automatic logic [31:0] class_busy(input logic [MAP_W-1:0] m, input cls_t c);
        logic [31:0] v;
        case (c)
            CLS_32:  v = m[31:0];
            CLS_64:  v = {16'hFFFF, m[47:32]};
            CLS_128: v = {24'hFF_FFFF, m[55:48]};
            CLS_512: v = {30'h3FFF_FFFF, m[57:56]};
            default: v = '1;
        endcase
        return v;
    endfunction

    // {found, lowest free index}
    function automatic logic [5:0] first_free(input logic [31:0] busy);
        logic [4:0] idx;
        idx = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (!busy[i])
                idx = 5'(i);
        end
        return {~&busy, idx};
    endfunction

    function automatic logic [5:0] class_bit(input cls_t c);
        logic [5:0] b;
        case (c)
            CLS_32:  b = 6'd0;
            CLS_64:  b = 6'd32;
            CLS_128: b = 6'd48;
            CLS_512: b = 6'd56;
            default: b = 6'd0;
        endcase
        return b;
    endfunction

    function automatic logic [MAP_W-1:0] bit_mask(input logic [5:0] b);
        return MAP_W'(1) << b;
    endfunction

    // byte offset of slot s of class c in page p, from the heap base
    function automatic logic [ADDR_W-1:0] slot_offset(input logic [PCNT_W-1:0] p,
                                                      input cls_t c,
                                                      input logic [4:0] s);
        logic [ADDR_W-1:0] so;
        case (c)
            CLS_32:  so = ADDR_W'(s) << 5;
            CLS_64:  so = ADDR_W'(s[3:0]) << 6;
            CLS_128: so = ADDR_W'(s[2:0]) << 7;
            CLS_512: so = ADDR_W'(s[0]) << 9;
            default: so = '0;
        endcase
        return (ADDR_W'(p) << 12) | (ADDR_W'(c) << 10) | so;
    endfunction

endpackage

`default_nettype wire

// File: src/size_class_slab_allocator_top.sv
// Size-class slab allocator over 4 KiB pages.
// Input channel (in_valid / in_stall): req_type 0 allocates req_size bytes,
// req_type 1 frees free_address. One result beat per request on the output
// channel (out_valid / out_stall): status, block_address, pages_in_use.
// heap_base is written through cfg_valid / cfg_ready while the block is idle.
// Requests are handled one at a time; in_stall stays high from acceptance
// until the result is loaded into the output register.
// Steps: a rejected request (zero size, too large, bad free address) goes
// from decode straight to finish; a free reads its page bitmap, checks and
// clears the slot, then finishes; an allocation scans the open pages in order,
// claims a slot in the first with one free, or opens a fresh page when all are full.
// The scan reads one page bitmap per cycle from the slot-map RAM through a
// single first-free-slot encoder, behind the registered RAM read.
// The output register holds a finished result while out_stall is high; the
// block accepts the next request meanwhile and waits at its end for the
// register to drain.
// Reset: slot map reads as empty (per-page valid bits cleared), one page
// open, heap_base 0, both channels empty. No clearing pass is needed.
`default_nettype none
`include "size_class_slab_allocator_top_defines.svh"

module size_class_slab_allocator_top #(
    parameter int MAX_PAGES = scsa_pkg::MAX_PAGES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        req_type,
    input  wire logic [15:0] req_size,
    input  wire logic [31:0] free_address,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [31:0]      block_address,
    output logic [6:0]       pages_in_use,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);

    localparam int AW     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PCNT_W = scsa_pkg::PCNT_W;
    localparam int MAP_W  = scsa_pkg::MAP_W;
    localparam int ADDR_W = scsa_pkg::ADDR_W;
    localparam logic [PCNT_W-1:0] PAGE_LIMIT = PCNT_W'(MAX_PAGES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_FREE_RD,
        S_FREE_CHK,
        S_FINISH
    } state_t;

    state_t                  state_reg, state_next;
    logic [ADDR_W-1:0]       heap_base_reg, heap_base_next;
    logic [PCNT_W-1:0]       page_count_reg, page_count_next;
    logic [MAX_PAGES-1:0]    pvalid_reg, pvalid_next;
    logic                    req_type_reg, req_type_next;
    logic [15:0]             req_size_reg, req_size_next;
    logic [ADDR_W-1:0]       free_addr_reg, free_addr_next;
    scsa_pkg::cls_t          cls_reg, cls_next;
    logic [PCNT_W-1:0]       rd_p_reg, rd_p_next;
    logic                    chk_valid_reg, chk_valid_next;
    logic [PCNT_W-1:0]       chk_p_reg, chk_p_next;
    logic [5:0]              slot_bit_reg, slot_bit_next;
    scsa_pkg::status_t       res_status_reg, res_status_next;
    logic [ADDR_W-1:0]       res_addr_reg, res_addr_next;
    logic                    out_valid_reg, out_valid_next;
    scsa_pkg::status_t       out_status_reg, out_status_next;
    logic [ADDR_W-1:0]       out_addr_reg, out_addr_next;
    logic [PCNT_W-1:0]       out_pages_reg, out_pages_next;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [MAP_W-1:0]        ram_wdata;
    logic [MAP_W-1:0]        ram_rdata;

    logic [MAP_W-1:0]        cur_map;
    logic [5:0]              ff_result;
    logic                    slot_found;
    logic [4:0]              slot_idx;
    logic [ADDR_W-1:0]       free_off;
    logic [11:0]             po;
    scsa_pkg::cls_t          free_cls;
    logic                    free_misalign;
    logic [4:0]              free_slot;

    scsa_ram #(
        .WIDTH (MAP_W),
        .DEPTH (MAX_PAGES)
    ) u_slot_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_p_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // a page never written reads as empty
    assign cur_map    = pvalid_reg[chk_p_reg[AW-1:0]] ? ram_rdata : '0;
    assign ff_result  = scsa_pkg::first_free(scsa_pkg::class_busy(cur_map, cls_reg));
    assign slot_found = ff_result[5];
    assign slot_idx   = ff_result[4:0];

    assign free_off = free_addr_reg - heap_base_reg;
    assign po       = free_off[11:0];
    assign free_cls = scsa_pkg::cls_t'(po[11:10]);

    always_comb
    begin
        free_misalign = 1'b0;
        free_slot     = '0;
        case (free_cls)
            scsa_pkg::CLS_32:
            begin
                free_misalign = (po[4:0] != '0);
                free_slot     = po[9:5];
            end
            scsa_pkg::CLS_64:
            begin
                free_misalign = (po[5:0] != '0);
                free_slot     = {1'b0, po[9:6]};
            end
            scsa_pkg::CLS_128:
            begin
                free_misalign = (po[6:0] != '0);
                free_slot     = {2'b0, po[9:7]};
            end
            scsa_pkg::CLS_512:
            begin
                free_misalign = (po[8:0] != '0);
                free_slot     = {4'b0, po[9]};
            end
            default:
            begin
                free_misalign = 1'b0;
                free_slot     = '0;
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        heap_base_next  = heap_base_reg;
        page_count_next = page_count_reg;
        pvalid_next     = pvalid_reg;
        req_type_next   = req_type_reg;
        req_size_next   = req_size_reg;
        free_addr_next  = free_addr_reg;
        cls_next        = cls_reg;
        rd_p_next       = rd_p_reg;
        chk_valid_next  = chk_valid_reg;
        chk_p_next      = chk_p_reg;
        slot_bit_next   = slot_bit_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_pages_next  = out_pages_reg;
        ram_we          = 1'b0;
        ram_waddr       = chk_p_reg[AW-1:0];
        ram_wdata       = cur_map | scsa_pkg::bit_mask(scsa_pkg::class_bit(cls_reg)
                                                       + 6'(slot_idx));

        if (cfg_valid && cfg_ready)
            heap_base_next = cfg_data;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_type_next  = req_type;
                    req_size_next  = req_size;
                    free_addr_next = free_address;
                    state_next     = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_addr_next = '0;
                if (!req_type_reg)
                begin
                    if (req_size_reg == '0)
                    begin
                        res_status_next = scsa_pkg::STAT_ZERO;
                        state_next      = S_FINISH;
                    end
                    else if (req_size_reg > 16'(scsa_pkg::MAX_BYTES))
                    begin
                        res_status_next = scsa_pkg::STAT_LARGE;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        cls_next       = scsa_pkg::size_class(req_size_reg);
                        rd_p_next      = '0;
                        chk_valid_next = 1'b0;
                        state_next     = S_SCAN;
                    end
                end
                else
                begin
                    if (free_off[31:12] >= 20'(page_count_reg))
                    begin
                        res_status_next = scsa_pkg::STAT_RANGE;
                        state_next      = S_FINISH;
                    end
                    else if (free_misalign)
                    begin
                        res_status_next = scsa_pkg::STAT_MISALIGN;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        rd_p_next     = free_off[12 +: PCNT_W];
                        chk_p_next    = free_off[12 +: PCNT_W];
                        slot_bit_next = scsa_pkg::class_bit(free_cls) + 6'(free_slot);
                        state_next    = S_FREE_RD;
                    end
                end
            end

            // read of page rd_p overlaps the check of page chk_p
            S_SCAN:
            begin
                if (chk_valid_reg && slot_found)
                begin
                    ram_we          = 1'b1;
                    pvalid_next[chk_p_reg[AW-1:0]] = 1'b1;
                    res_status_next = scsa_pkg::STAT_OK;
                    res_addr_next   = heap_base_reg
                                      + scsa_pkg::slot_offset(chk_p_reg, cls_reg, slot_idx);
                    state_next      = S_FINISH;
                end
                else if (!chk_valid_reg && (rd_p_reg >= page_count_reg))
                begin
                    if (page_count_reg < PAGE_LIMIT)
                    begin
                        // fresh page: claim its first slot
                        ram_we          = 1'b1;
                        ram_waddr       = page_count_reg[AW-1:0];
                        ram_wdata       = scsa_pkg::bit_mask(scsa_pkg::class_bit(cls_reg));
                        pvalid_next[page_count_reg[AW-1:0]] = 1'b1;
                        page_count_next = page_count_reg + PCNT_W'(1);
                        res_status_next = scsa_pkg::STAT_OK;
                        res_addr_next   = heap_base_reg
                                          + scsa_pkg::slot_offset(page_count_reg, cls_reg,
                                                                  5'd0);
                    end
                    else
                    begin
                        res_status_next = scsa_pkg::STAT_OOM;
                        res_addr_next   = '0;
                    end
                    state_next = S_FINISH;
                end
                else if (rd_p_reg < page_count_reg)
                begin
                    chk_valid_next = 1'b1;
                    chk_p_next     = rd_p_reg;
                    rd_p_next      = rd_p_reg + PCNT_W'(1);
                end
                else
                begin
                    chk_valid_next = 1'b0;
                end
            end

            S_FREE_RD:
            begin
                state_next = S_FREE_CHK;
            end

            S_FREE_CHK:
            begin
                res_addr_next = '0;
                if (!cur_map[slot_bit_reg])
                begin
                    res_status_next = scsa_pkg::STAT_NOTALLOC;
                end
                else
                begin
                    ram_we          = 1'b1;
                    ram_wdata       = cur_map & ~scsa_pkg::bit_mask(slot_bit_reg);
                    res_status_next = scsa_pkg::STAT_OK;
                end
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    out_pages_next  = page_count_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            heap_base_reg  <= '0;
            page_count_reg <= PCNT_W'(1);
            pvalid_reg     <= '0;
            req_type_reg   <= 1'b0;
            req_size_reg   <= '0;
            free_addr_reg  <= '0;
            cls_reg        <= scsa_pkg::CLS_32;
            rd_p_reg       <= '0;
            chk_valid_reg  <= 1'b0;
            chk_p_reg      <= '0;
            slot_bit_reg   <= '0;
            res_status_reg <= scsa_pkg::STAT_OK;
            res_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= scsa_pkg::STAT_OK;
            out_addr_reg   <= '0;
            out_pages_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            heap_base_reg  <= heap_base_next;
            page_count_reg <= page_count_next;
            pvalid_reg     <= pvalid_next;
            req_type_reg   <= req_type_next;
            req_size_reg   <= req_size_next;
            free_addr_reg  <= free_addr_next;
            cls_reg        <= cls_next;
            rd_p_reg       <= rd_p_next;
            chk_valid_reg  <= chk_valid_next;
            chk_p_reg      <= chk_p_next;
            slot_bit_reg   <= slot_bit_next;
            res_status_reg <= res_status_next;
            res_addr_reg   <= res_addr_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_addr_reg   <= out_addr_next;
            out_pages_reg  <= out_pages_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign block_address = out_addr_reg;
    assign pages_in_use  = out_pages_reg;

    `SCSA_ASSERT(a_page_grow_by_one, clk, rst_n, (page_count_reg != $past(page_count_reg)) |-> (page_count_reg == $past(page_count_reg) + PCNT_W'(1)), "page count moved by more than one")
    `SCSA_ASSERT(a_out_from_finish, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == S_FINISH), "result beat not loaded from finish")
    `SCSA_ASSERT(a_oom_only_full, clk, rst_n, (out_valid_reg && (out_status_reg == scsa_pkg::STAT_OOM)) |-> (out_pages_reg == PAGE_LIMIT), "out of memory with pages left")
    `SCSA_ASSERT(a_err_zero_addr, clk, rst_n, (out_valid_reg && (out_status_reg != scsa_pkg::STAT_OK)) |-> (out_addr_reg == '0), "error beat with nonzero address")
    `SCSA_ASSERT_ALWAYS(a_pages_reported, clk, out_valid_reg |-> (out_pages_reg <= page_count_reg), "reported pages exceed open pages")

endmodule

`default_nettype wire

// File: src/scsa_ram.sv
`default_nettype none

module scsa_ram #(
    parameter int WIDTH = scsa_pkg::MAP_W,
    parameter int DEPTH = scsa_pkg::MAX_PAGES_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: test/slab_alloc_checker.sv
`timescale 1ns / 100ps

module slab_alloc_checker #(
    parameter int MAX_PAGES = scsa_pkg::MAX_PAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        req_type,
    input  logic [15:0] req_size,
    input  logic [31:0] free_address,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  status,
    input  logic [31:0] block_address,
    input  logic [6:0]  pages_in_use,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output int          mismatch_count,
    output int          outstanding
);
    import scsa_pkg::*;

    typedef struct packed {
        status_t     st;
        logic [31:0] addr;
        logic [6:0]  pages;
    } alloc_result_t;

    logic [MAP_W-1:0] busy_map [MAX_PAGES];
    int unsigned      open_pages;
    logic [31:0]      base_addr;
    alloc_result_t    expected_results [$];
    alloc_result_t    want;
    int               fail_total;

    function automatic int unsigned class_log2(input cls_t c);
        return (c == CLS_512) ? 9 : 5 + int'(c);
    endfunction

    function automatic int unsigned class_first_bit(input cls_t c);
        case (c)
            CLS_32:  return 0;
            CLS_64:  return 32;
            CLS_128: return 48;
            default: return 56;
        endcase
    endfunction

    // updates the slot map and page count as the block should
    function automatic alloc_result_t predict_request(input logic req_is_free,
                                                      input logic [15:0] sz,
                                                      input logic [31:0] fa);
        alloc_result_t r;
        cls_t          c;
        int unsigned   lg, first, slots, slot, pg, scan_pages;
        logic [31:0]   off;
        logic [11:0]   in_page;
        bit            found;
        r.st  = STAT_OK;
        r.addr = '0;
        found = 1'b0;
        slot  = 0;
        pg    = 0;
        if (!req_is_free)
        begin
            if (sz == 16'd0)
                r.st = STAT_ZERO;
            else if (sz > 16'(MAX_BYTES))
                r.st = STAT_LARGE;
            else
            begin
                if (sz <= 16'd32)
                    c = CLS_32;
                else if (sz <= 16'd64)
                    c = CLS_64;
                else if (sz <= 16'd128)
                    c = CLS_128;
                else
                    c = CLS_512;
                lg    = class_log2(c);
                first = class_first_bit(c);
                slots = 1024 >> lg;
                // one page past the open ones is still empty, so it can be scanned too
                scan_pages = (open_pages < MAX_PAGES) ? open_pages + 1 : open_pages;
                for (int p = 0; p < scan_pages && !found; p++)
                    for (int s = 0; s < slots && !found; s++)
                        if (!busy_map[p][first + s])
                        begin
                            found = 1'b1;
                            pg    = p;
                            slot  = s;
                        end
                if (found)
                begin
                    if (pg == open_pages)
                        open_pages++;
                    busy_map[pg][first + slot] = 1'b1;
                    r.addr = base_addr + (32'(pg) << 12) + (32'(c) << 10) + (32'(slot) << lg);
                end
                else
                    r.st = STAT_OOM;
            end
        end
        else
        begin
            off     = fa - base_addr;
            in_page = off[11:0];
            c       = cls_t'(in_page[11:10]);
            lg      = class_log2(c);
            first   = class_first_bit(c);
            if (off[31:12] >= open_pages)
                r.st = STAT_RANGE;
            else if ((in_page & ((12'd1 << lg) - 12'd1)) != 12'd0)
                r.st = STAT_MISALIGN;
            else
            begin
                pg   = off[31:12];
                slot = in_page[9:0] >> lg;
                if (!busy_map[pg][first + slot])
                    r.st = STAT_NOTALLOC;
                else
                    busy_map[pg][first + slot] = 1'b0;
            end
        end
        r.pages = 7'(open_pages);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PAGES; i++)
                busy_map[i] = '0;
            open_pages = 1;
            base_addr  = '0;
            expected_results.delete();
            fail_total = 0;
            mismatch_count <= 0;
            outstanding    <= 0;
        end
        else
        begin
            // a result beat always belongs to an earlier request, so check first
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%t: result beat with nothing pending: status %0d addr %h pages %0d",
                                 $realtime, status, block_address, pages_in_use);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.st || block_address !== want.addr
                        || pages_in_use !== want.pages)
                    begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display("%t: mismatch exp/got status %0d/%0d addr %h/%h pages %0d/%0d",
                                     $realtime, want.st, status, want.addr, block_address,
                                     want.pages, pages_in_use);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                base_addr = cfg_data;
            if (in_valid && !in_stall)
                expected_results.push_back(predict_request(req_type, req_size, free_address));
            mismatch_count <= fail_total;
            outstanding    <= expected_results.size();
        end
    end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import scsa_pkg::*;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_FREE    = 1'b1;
    localparam int   CYCLE_LIMIT = 500000;
    localparam int   HOLD_CYCLES = 400;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic        req_type     = 1'b0;
    logic [15:0] req_size     = '0;
    logic [31:0] free_address = '0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [2:0]  status;
    logic [31:0] block_address;
    logic [6:0]  pages_in_use;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data     = '0;

    int          mismatch_count;
    int          outstanding;
    int          cycle_count  = 0;
    logic        quiet        = 1'b0;
    logic        hold_go      = 1'b0;
    logic        hold_off     = 1'b0;
    logic [31:0] heap_base_now = '0;
    logic [31:0] live_blocks [$];
    int unsigned pages_seen   = 1;

    size_class_slab_allocator_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .req_size      (req_size),
        .free_address  (free_address),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .block_address (block_address),
        .pages_in_use  (pages_in_use),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    slab_alloc_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .req_size       (req_size),
        .free_address   (free_address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .block_address  (block_address),
        .pages_in_use   (pages_in_use),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= hold_off || (!quiet && $urandom_range(99) < 7);

    // one long hold-off so the block backs up into its input
    initial
    begin
        do @(posedge clk); while (!hold_go);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // addresses handed out feed later frees; sampled mid-cycle, away from the drive edge
    always @(negedge clk)
        if (rst_n && out_valid && !out_stall)
        begin
            if (pages_in_use > pages_seen)
                pages_seen = pages_in_use;
            if (status == STAT_OK && block_address != '0)
                live_blocks.push_back(block_address);
        end

    task automatic send_req(input logic kind, input logic [15:0] sz, input logic [31:0] fa);
        if (!quiet && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= kind;
        req_size     <= sz;
        free_address <= fa;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic request_alloc(input logic [15:0] sz);
        send_req(REQ_ALLOC, sz, $urandom);
    endtask

    task automatic request_free(input logic [31:0] fa);
        send_req(REQ_FREE, 16'($urandom), fa);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_base(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        heap_base_now = value;
        live_blocks.delete();
    endtask

    task automatic random_request();
        int unsigned pick, lg, idx;
        cls_t        cls;
        logic [31:0] fa;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            pick = $urandom_range(99);
            cls  = cls_t'($urandom_range(3));
            if (pick < 4)
                request_alloc(16'd0);
            else if (pick < 10)
                request_alloc(16'($urandom_range(513, 65535)));
            else
                case (cls)
                    CLS_32:  request_alloc(16'($urandom_range(1, 32)));
                    CLS_64:  request_alloc(16'($urandom_range(33, 64)));
                    CLS_128: request_alloc(16'($urandom_range(65, 128)));
                    default: request_alloc(16'($urandom_range(129, 512)));
                endcase
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 55 && live_blocks.size() > 0)
            begin
                idx = $urandom_range(0, live_blocks.size() - 1);
                fa  = live_blocks[idx];
                live_blocks.delete(idx);
            end
            else if (pick < 90)
            begin
                // slot-shaped address, page up to one past the open ones
                cls = cls_t'($urandom_range(3));
                lg  = (cls == CLS_512) ? 9 : 5 + int'(cls);
                fa  = heap_base_now + (32'($urandom_range(0, pages_seen)) << 12)
                      + (32'(cls) << 10) + (32'($urandom_range(0, (1024 >> lg) - 1)) << lg);
                if (pick >= 80)
                    fa = fa + 32'($urandom_range(1, 31));
            end
            else
                fa = $urandom;
            request_free(fa);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_base(32'h0000_0000);
        request_alloc(16'd0);
        request_alloc(16'd513);
        request_alloc(16'hFFFF);
        request_alloc(16'd1);
        request_alloc(16'd32);
        request_alloc(16'd33);
        request_alloc(16'd64);
        request_alloc(16'd65);
        request_alloc(16'd128);
        request_alloc(16'd129);
        request_alloc(16'd512);
        request_alloc(16'd300);          // 512 class full in page 0, opens page 1
        request_free(32'h0000_0020);
        request_free(32'h0000_0020);     // double free
        request_free(32'h0000_0404);
        request_free(32'h0000_0810);
        request_free(32'h0000_0D00);
        request_free(32'h0000_2000);     // page not open yet
        request_free(32'hFFFF_FFFF);
        request_free(32'h0000_1E00);     // never allocated
        request_free(32'h0000_0001);
        request_alloc(16'd20);
        request_free(32'h0000_1C00);
        request_alloc(16'd512);
        settle();

        // no idling on either side; returned addresses wrap past the top
        quiet <= 1'b1;
        write_base(32'hFFFF_F000);
        repeat (120) random_request();
        settle();
        quiet <= 1'b0;

        write_base($urandom | 32'h0000_0008);
        hold_go <= 1'b1;
        repeat (110) random_request();
        settle();

        // exhaust the 512-byte class across all pages, then mix
        write_base(32'hFFFF_FFFF);
        repeat (70) request_alloc(16'($urandom_range(129, 512)));
        repeat (90) random_request();
        settle();

        write_base($urandom & 32'hFFFF_F000);
        repeat (40) random_request();
        settle();
        repeat (40) @(posedge clk);

        if (mismatch_count == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
